>>> hdl/lbp_pkg.sv
package lbp_pkg;

  localparam int CMD_W     = 2;
  localparam int PAGE_ID_W = 16;
  localparam int CFG_W     = 5;
  localparam int STATUS_W  = 3;
  localparam int FRAME_W   = 4;
  localparam int EVICT_W   = 16;
  localparam int OUT_DW    = 24;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd10;

  localparam logic [CMD_W-1:0] CMD_FETCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_MISS_EVICT  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ALL_PINNED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_RESIDENT = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EVICT,
    S_RENUM
  } state_t;

  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_PROMOTE,
    TOP_INSERT,
    TOP_UNPIN,
    TOP_RENUM,
    TOP_CLIP
  } tbl_op_t;

  typedef struct packed {
    tbl_op_t op;
    logic    set_pin;
  } tbl_ctl_t;

endpackage

>>> hdl/lru_buffer_pool_replacer.sv
// LRU buffer-pool frame manager. Each item is a request (tuser: 0 fetch and
// pin, 1 touch, 2 unpin; tdata: page number) and gives one result
// (tuser: status; tdata: frame, evicted page), but none if a write of
// frames_in_use arrives during its scan. Items are handled one at a time: a
// single pass over the active frames (those below the clamped frames_in_use
// value) reads the page RAM one entry per cycle while one comparator checks
// for the page, the lowest free frame and the oldest unpinned frame. A result
// waiting on the output register does not block acceptance of the next
// item. A write of frames_in_use frees frames at or above the new limit and
// then compacts the recency ranks, stepping from rank FRAMES-1 down to 0,
// during which no item is accepted.
module lru_buffer_pool_replacer import lbp_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PAGE_ID_W-1:0] in_tdata,   // [15:0] page_id
  input  logic [CMD_W-1:0]     in_tuser,   // [1:0] command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DW-1:0]    out_tdata,  // [3:0] frame, [19:4] evicted_page
  output logic [STATUS_W-1:0]  out_tuser,  // [2:0] status
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  function automatic logic [CW-1:0] clamp_lim(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) r = CW'(1);
    else if (32'(v) > FRAMES) r = CW'(FRAMES);
    else r = CW'(v);
    return r;
  endfunction

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     limit_r, limit_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [CW-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic [IW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic                 hit_r, hit_nxt;
  logic [IW-1:0]        hit_idx_r, hit_idx_nxt;
  logic                 free_r, free_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic                 vic_r, vic_nxt;
  logic [IW-1:0]        vic_idx_r, vic_idx_nxt;
  logic [IW-1:0]        best_r, best_nxt;
  logic [IW-1:0]        renum_t_r, renum_t_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic [EVICT_W-1:0]   out_evict_r, out_evict_nxt;

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [PAGE_BITS-1:0] mem_q_r;
  logic [IW-1:0]        rd_addr;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;

  tbl_ctl_t             tctl;
  logic [IW-1:0]        tidx;
  logic [FRAMES-1:0]    used;
  logic [FRAMES-1:0]    pinned;
  logic [IW-1:0]        cmp_rank;
  logic [CW-1:0]        lim;
  logic [CW-1:0]        cfg_lim;
  logic                 out_free;

  assign lim       = clamp_lim(limit_r);
  assign cfg_lim   = clamp_lim(cfg_wr_data);
  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && !cfg_wr_en;

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_evict_r, out_frame_r};

  assign rd_addr = (state_r == S_SCAN) ? scan_cnt_r[IW-1:0] : vic_idx_r;

  lbp_table #(
    .FRAMES (FRAMES),
    .IW     (IW),
    .CW     (CW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tctl),
    .idx      (tidx),
    .clip_lim (cfg_lim),
    .rd_idx   (cmp_idx_r),
    .used_o   (used),
    .pinned_o (pinned),
    .rd_rank  (cmp_rank)
  );

  always_ff @(posedge clk) begin
    if (mem_we) page_mem[mem_waddr] <= page_r;
    mem_q_r <= page_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    vic_nxt        = vic_r;
    vic_idx_nxt    = vic_idx_r;
    best_nxt       = best_r;
    renum_t_nxt    = renum_t_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_evict_nxt  = out_evict_r;
    mem_we         = 1'b0;
    mem_waddr      = free_idx_r;
    tctl.op        = TOP_NONE;
    tctl.set_pin   = 1'b0;
    tidx           = hit_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt      = in_tuser;
          page_nxt     = PAGE_BITS'(in_tdata);
          scan_cnt_nxt = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          vic_nxt      = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r < lim) begin
          scan_cnt_nxt = CW'(scan_cnt_r + 1'b1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_cnt_r[IW-1:0];
        end
        if (cmp_vld_r) begin
          if (used[cmp_idx_r] && mem_q_r == page_r && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
          end
          if (!used[cmp_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (used[cmp_idx_r] && !pinned[cmp_idx_r] && (!vic_r || cmp_rank > best_r)) begin
            vic_nxt     = 1'b1;
            vic_idx_nxt = cmp_idx_r;
            best_nxt    = cmp_rank;
          end
        end else if (scan_cnt_r == lim) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = STAT_HIT;
          out_frame_nxt  = '0;
          out_evict_nxt  = '0;
          state_nxt      = S_IDLE;
          unique case (cmd_r) inside
            CMD_FETCH: begin
              if (hit_r) begin
                tctl.op       = TOP_PROMOTE;
                tctl.set_pin  = 1'b1;
                out_frame_nxt = FRAME_W'(hit_idx_r);
              end else if (free_r) begin
                tctl.op        = TOP_INSERT;
                tidx           = free_idx_r;
                mem_we         = 1'b1;
                out_status_nxt = STAT_MISS_FREE;
                out_frame_nxt  = FRAME_W'(free_idx_r);
              end else if (vic_r) begin
                out_vld_nxt = 1'b0;
                state_nxt   = S_EVICT;
              end else begin
                out_status_nxt = STAT_ALL_PINNED;
              end
            end
            CMD_TOUCH, CMD_UNPIN: begin
              if (hit_r) begin
                tctl.op       = (cmd_r == CMD_TOUCH) ? TOP_PROMOTE : TOP_UNPIN;
                out_frame_nxt = FRAME_W'(hit_idx_r);
              end else begin
                out_status_nxt = STAT_NOT_RESIDENT;
              end
            end
            default: ;
          endcase
        end
      end
      S_EVICT: begin
        // mem_q_r holds the victim's old page
        if (out_free) begin
          tctl.op        = TOP_PROMOTE;
          tctl.set_pin   = 1'b1;
          tidx           = vic_idx_r;
          mem_we         = 1'b1;
          mem_waddr      = vic_idx_r;
          out_vld_nxt    = 1'b1;
          out_status_nxt = STAT_MISS_EVICT;
          out_frame_nxt  = FRAME_W'(vic_idx_r);
          out_evict_nxt  = EVICT_W'(mem_q_r);
          state_nxt      = S_IDLE;
        end
      end
      S_RENUM: begin
        tctl.op = TOP_RENUM;
        tidx    = renum_t_r;
        if (renum_t_r == '0) state_nxt = S_IDLE;
        else renum_t_nxt = IW'(renum_t_r - 1'b1);
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr_en) begin
      limit_nxt    = cfg_wr_data;
      tctl.op      = TOP_CLIP;
      tctl.set_pin = 1'b0;
      mem_we       = 1'b0;
      renum_t_nxt  = IW'(FRAMES - 1);
      state_nxt    = S_RENUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      limit_r   <= LIMIT_RESET;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      limit_r   <= limit_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    vic_r        <= vic_nxt;
    vic_idx_r    <= vic_idx_nxt;
    best_r       <= best_nxt;
    renum_t_r    <= renum_t_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_evict_r  <= out_evict_nxt;
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !(in_tvalid && in_tready) && !cfg_wr_en) |=> state_r == S_IDLE)
    else $error("sequencer left idle without a request");

  a_evict_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> (cmd_r == CMD_FETCH))
    else $error("eviction for a command other than fetch");

  a_used_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used) <= int'(lim))
    else $error("more frames in use than the limit allows");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r <= lim))
    else $error("scan ran past the frame limit");

endmodule

>>> hdl/lbp_table.sv
module lbp_table import lbp_pkg::*; #(
  parameter int FRAMES = 16,
  parameter int IW     = $clog2(FRAMES),
  parameter int CW     = $clog2(FRAMES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tbl_ctl_t          ctl,
  input  logic [IW-1:0]     idx,
  input  logic [CW-1:0]     clip_lim,
  input  logic [IW-1:0]     rd_idx,
  output logic [FRAMES-1:0] used_o,
  output logic [FRAMES-1:0] pinned_o,
  output logic [IW-1:0]     rd_rank
);

  logic [FRAMES-1:0] used_r, used_nxt;
  logic [FRAMES-1:0] pinned_r, pinned_nxt;
  logic [IW-1:0]     rank_r   [FRAMES];
  logic [IW-1:0]     rank_nxt [FRAMES];
  logic [IW-1:0]     sel_rank;
  logic              present;

  assign used_o   = used_r;
  assign pinned_o = pinned_r;
  assign rd_rank  = rank_r[rd_idx];
  assign sel_rank = rank_r[idx];

  always_comb begin
    present = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      if (used_r[i] && rank_r[i] == idx) present = 1'b1;
    end
  end

  always_comb begin
    used_nxt   = used_r;
    pinned_nxt = pinned_r;
    rank_nxt   = rank_r;
    unique case (ctl.op)
      TOP_PROMOTE: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (IW'(i) != idx && used_r[i] && rank_r[i] < sel_rank)
            rank_nxt[i] = IW'(rank_r[i] + 1'b1);
        end
        rank_nxt[idx] = '0;
        if (ctl.set_pin) pinned_nxt[idx] = 1'b1;
      end
      TOP_INSERT: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (IW'(i) != idx && used_r[i])
            rank_nxt[i] = IW'(rank_r[i] + 1'b1);
        end
        rank_nxt[idx]   = '0;
        used_nxt[idx]   = 1'b1;
        pinned_nxt[idx] = 1'b1;
      end
      TOP_UNPIN: begin
        pinned_nxt[idx] = 1'b0;
      end
      TOP_RENUM: begin
        // close the gap at rank idx if no used frame holds it
        if (!present) begin
          for (int i = 0; i < FRAMES; i++) begin
            if (used_r[i] && rank_r[i] > idx)
              rank_nxt[i] = IW'(rank_r[i] - 1'b1);
          end
        end
      end
      TOP_CLIP: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (CW'(i) >= clip_lim) begin
            used_nxt[i]   = 1'b0;
            pinned_nxt[i] = 1'b0;
            rank_nxt[i]   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      pinned_r <= '0;
      for (int i = 0; i < FRAMES; i++) rank_r[i] <= '0;
    end else begin
      used_r   <= used_nxt;
      pinned_r <= pinned_nxt;
      rank_r   <= rank_nxt;
    end
  end

endmodule
